### hdl/edmt_pkg.sv
`default_nettype none

package edmt_pkg;

    localparam int EGG_W   = 5;
    localparam int FLOOR_W = 11;
    localparam int DROPS_W = 11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_ROW0,
        S_ROW1,
        S_CELL,
        S_READ,
        S_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### hdl/egg_drop_min_trials_unit.sv
`default_nettype none

// channel | direction | handshake          | payload
// query   | in        | i_valid / o_ready  | i_egg_count, i_floor_count
// answer  | out       | o_valid / i_ready  | o_min_drops
//
// one query word at a time; a query of e eggs and n floors builds e rows of n + 1 cells
// one binary-search step per cycle, set by the single read port of each row memory
// synchronous active-low reset returns to idle with no answer pending
// a finished answer waits in the output register; the next query is taken once it is loaded

module egg_drop_min_trials_unit
    import edmt_pkg::*;
#(
    parameter int MAX_EGGS   = 16,
    parameter int MAX_FLOORS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [EGG_W-1:0]   i_egg_count,
    input  wire logic [FLOOR_W-1:0] i_floor_count,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [DROPS_W-1:0]      o_min_drops
);

    localparam int DEPTH = MAX_FLOORS + 1;
    localparam int FW    = $clog2(DEPTH);
    localparam int LW    = FW + 1;
    localparam int EW    = $clog2(MAX_EGGS + 1);

    logic [FW-1:0] mem0 [0:DEPTH-1];
    logic [FW-1:0] mem1 [0:DEPTH-1];
    logic [FW-1:0] r_rd0, r_rd1;

    t_state r_state, n_state;
    logic [EW-1:0]      r_eggs, n_eggs;
    logic [EW-1:0]      r_e, n_e;
    logic [FW-1:0]      r_n, n_n;
    logic [FW-1:0]      r_j, n_j;
    logic [LW-1:0]      r_lo, n_lo;
    logic [LW-1:0]      r_hi, n_hi;
    logic [LW-1:0]      r_mid, n_mid;
    logic [FW-1:0]      r_best, n_best;
    logic               r_bank, n_bank;
    logic [DROPS_W-1:0] r_result, n_result;
    logic               r_o_valid, n_o_valid;

    logic          wr_en;
    logic [FW-1:0] wr_addr, wr_data;
    logic [FW-1:0] rd_cur_addr, rd_prev_addr;
    logic [FW-1:0] raddr0, raddr1;
    logic [FW-1:0] cur_q, prev_q;

    logic [EW-1:0] eggs_sat;
    logic [FW-1:0] floors_sat;

    logic [FW-1:0] worst, step_best;
    logic          go_low;
    logic [LW-1:0] step_lo, step_hi, step_mid;
    logic          cell_start, row_done;
    logic [LW-1:0] next_j, start_mid;

    // row memories, one being built and one finished
    assign raddr0 = r_bank ? rd_prev_addr : rd_cur_addr;
    assign raddr1 = r_bank ? rd_cur_addr  : rd_prev_addr;
    assign cur_q  = r_bank ? r_rd1 : r_rd0;
    assign prev_q = r_bank ? r_rd0 : r_rd1;

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_bank) begin
            mem0[wr_addr] <= wr_data;
        end
        r_rd0 <= mem0[raddr0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_bank) begin
            mem1[wr_addr] <= wr_data;
        end
        r_rd1 <= mem1[raddr1];
    end

    always_comb begin
        if (i_egg_count == '0) begin
            eggs_sat = EW'(1);
        end else if (int'(i_egg_count) > MAX_EGGS) begin
            eggs_sat = EW'(MAX_EGGS);
        end else begin
            eggs_sat = EW'(i_egg_count);
        end
        if (int'(i_floor_count) > MAX_FLOORS) begin
            floors_sat = FW'(MAX_FLOORS);
        end else begin
            floors_sat = FW'(i_floor_count);
        end
    end

    // one search step on the words read for r_mid
    always_comb begin
        go_low    = cur_q > prev_q;
        worst     = (go_low ? cur_q : prev_q) + FW'(1);
        step_best = (worst < r_best) ? worst : r_best;
        step_lo   = go_low ? r_lo : r_mid + LW'(1);
        step_hi   = go_low ? r_mid - LW'(1) : r_hi;
        step_mid  = step_lo + ((step_hi - step_lo) >> 1);
    end

    always_comb begin
        n_state     = r_state;
        n_eggs      = r_eggs;
        n_e         = r_e;
        n_n         = r_n;
        n_j         = r_j;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_best      = r_best;
        n_bank      = r_bank;
        n_result    = r_result;
        n_o_valid   = r_o_valid;
        wr_en       = 1'b0;
        wr_addr     = r_j;
        wr_data     = r_j;
        rd_cur_addr = FW'(r_mid - LW'(1));
        rd_prev_addr = FW'(LW'(r_j) - r_mid);
        o_ready     = 1'b0;
        cell_start  = 1'b0;
        row_done    = 1'b0;
        next_j      = LW'(r_j) + LW'(1);

        if (i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_eggs  = eggs_sat;
                    n_n     = floors_sat;
                    n_e     = EW'(1);
                    n_j     = '0;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_j;
                if (r_j == r_n) begin
                    row_done = 1'b1;
                end else begin
                    n_j = r_j + FW'(1);
                end
            end
            S_ROW0: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '0;
                if (r_n == '0) begin
                    row_done = 1'b1;
                end else begin
                    n_state = S_ROW1;
                end
            end
            S_ROW1: begin
                wr_en   = 1'b1;
                wr_addr = FW'(1);
                wr_data = FW'(1);
                if (r_n == FW'(1)) begin
                    row_done = 1'b1;
                end else begin
                    cell_start = 1'b1;
                    next_j     = LW'(2);
                end
            end
            S_CELL: begin
                if (step_lo <= step_hi) begin
                    n_lo         = step_lo;
                    n_hi         = step_hi;
                    n_mid        = step_mid;
                    n_best       = step_best;
                    rd_cur_addr  = FW'(step_mid - LW'(1));
                    rd_prev_addr = FW'(LW'(r_j) - step_mid);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = step_best;
                    if (r_j == r_n) begin
                        row_done = 1'b1;
                    end else begin
                        cell_start = 1'b1;
                    end
                end
            end
            S_READ: begin
                rd_prev_addr = r_n;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                rd_prev_addr = r_n;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // keep the answer cell on the read port until the output register is free
                rd_prev_addr = r_n;
                if (!r_o_valid || i_ready) begin
                    n_result  = DROPS_W'(prev_q);
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        start_mid = LW'(1) + ((next_j - LW'(1)) >> 1);

        // first probe of the next cell
        if (cell_start) begin
            n_j          = FW'(next_j);
            n_lo         = LW'(1);
            n_hi         = next_j;
            n_mid        = start_mid;
            n_best       = '1;
            rd_cur_addr  = FW'(start_mid - LW'(1));
            rd_prev_addr = FW'(next_j - start_mid);
            n_state      = S_CELL;
        end

        // finished row becomes the previous one
        if (row_done) begin
            n_bank = ~r_bank;
            if (r_e == r_eggs) begin
                n_state = S_READ;
            end else begin
                n_e     = r_e + EW'(1);
                n_state = S_ROW0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_bank    <= 1'b0;
            r_e       <= EW'(1);
            r_eggs    <= EW'(1);
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_bank    <= n_bank;
            r_e       <= n_e;
            r_eggs    <= n_eggs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_j      <= n_j;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_best   <= n_best;
        r_result <= n_result;
    end

    assign o_valid     = r_o_valid;
    assign o_min_drops = r_result;

    a_egg_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_e <= r_eggs))
        else $error("egg row beyond requested count");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_lo >= LW'(1) && r_lo <= r_hi && r_hi <= LW'(r_j)))
        else $error("search window outside cell");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_j >= FW'(2) && r_j <= r_n))
        else $error("cell index outside row");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_BASE))
        else $error("accepted word did not start the base row");

    a_answer_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("answer raised outside output step");

endmodule

`default_nettype wire

### bench/tb_egg_drop_min_trials_unit.sv
`timescale 1ns / 100ps

module tb_egg_drop_min_trials_unit;
    import edmt_pkg::*;

    localparam int MAX_EGGS   = 16;
    localparam int MAX_FLOORS = 1024;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [EGG_W-1:0]   i_egg_count = '0;
    logic [FLOOR_W-1:0] i_floor_count = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [DROPS_W-1:0] o_min_drops;

    logic [DROPS_W-1:0] expected_drops[$];
    int unsigned        query_idle_pct = 0;
    int unsigned        answer_stall_pct = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        queries_sent = 0;
    int unsigned        answers_checked = 0;

    egg_drop_min_trials_unit #(
        .MAX_EGGS   (MAX_EGGS),
        .MAX_FLOORS (MAX_FLOORS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_egg_count   (i_egg_count),
        .i_floor_count (i_floor_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_min_drops   (o_min_drops)
    );

    always #2 i_clk = ~i_clk;

    // worst-case drops over a two-row table, binary search on the first drop floor
    function automatic logic [DROPS_W-1:0] fewest_drops(input logic [EGG_W-1:0] eggs_in,
                                                        input logic [FLOOR_W-1:0] floors_in);
        int unsigned fewer_eggs_row [0:MAX_FLOORS];
        int unsigned this_eggs_row [0:MAX_FLOORS];
        int unsigned eggs;
        int unsigned floors;
        int unsigned best;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned broke;
        int unsigned kept;
        int unsigned worst;
        eggs = 32'(eggs_in);
        floors = 32'(floors_in);
        if (eggs == 0) begin
            eggs = 1;
        end
        if (eggs > MAX_EGGS) begin
            eggs = MAX_EGGS;
        end
        if (floors > MAX_FLOORS) begin
            floors = MAX_FLOORS;
        end
        for (int j = 0; j <= floors; j++) begin
            fewer_eggs_row[j] = j;
        end
        for (int e = 2; e <= eggs; e++) begin
            this_eggs_row[0] = 0;
            if (floors >= 1) begin
                this_eggs_row[1] = 1;
            end
            for (int j = 2; j <= floors; j++) begin
                best = 32'hFFFF_FFFF;
                lo = 1;
                hi = j;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    broke = this_eggs_row[mid - 1];
                    kept = fewer_eggs_row[j - mid];
                    worst = ((broke > kept) ? broke : kept) + 1;
                    if (worst < best) begin
                        best = worst;
                    end
                    if (broke > kept) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                this_eggs_row[j] = best;
            end
            for (int j = 0; j <= floors; j++) begin
                fewer_eggs_row[j] = this_eggs_row[j];
            end
        end
        return fewer_eggs_row[floors][DROPS_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // called at a rising edge; leaves valid high after the word is taken
    task automatic send_query(input logic [EGG_W-1:0] eggs, input logic [FLOOR_W-1:0] floors);
        while ($urandom_range(99) < query_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_egg_count <= eggs;
        i_floor_count <= floors;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        expected_drops = {expected_drops, fewest_drops(eggs, floors)};
        queries_sent++;
    endtask

    task automatic wait_for_answers();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_drops.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= answer_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_drops.size() == 0) begin
                report_mismatch("unexpected answer word, min_drops", 32'(o_min_drops), 0);
            end else begin
                if (o_min_drops !== expected_drops[0]) begin
                    report_mismatch("min_drops", 32'(o_min_drops), 32'(expected_drops[0]));
                end
                void'(expected_drops.pop_front());
                answers_checked++;
            end
        end
    end

    task automatic test_base_cases();
        send_query(5'd1, 11'd0);
        send_query(5'd2, 11'd0);
        send_query(5'd16, 11'd0);
        send_query(5'd1, 11'd1);
        send_query(5'd7, 11'd1);
        send_query(5'd16, 11'd1);
        send_query(5'd1, 11'd2);
        send_query(5'd2, 11'd2);
        send_query(5'd1, 11'd100);
        send_query(5'd0, 11'd37);
        send_query(5'd0, 11'd0);
        send_query(5'd2, 11'd10);
        send_query(5'd2, 11'd36);
        send_query(5'd3, 11'd14);
    endtask

    task automatic test_field_extremes();
        send_query(5'd16, 11'd1024);
        send_query(5'd31, 11'd2047);
        send_query(5'd17, 11'd20);
        send_query(5'd31, 11'd0);
        send_query(5'd1, 11'd1024);
        send_query(5'd1, 11'd2047);
        send_query(5'd0, 11'd1025);
        send_query(5'd2, 11'd1024);
        send_query(5'd2, 11'd2047);
    endtask

    // mostly short towers with any egg count, some tall towers with few eggs
    task automatic test_random_queries(input int count);
        logic [EGG_W-1:0]   eggs;
        logic [FLOOR_W-1:0] floors;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 85) begin
                eggs = EGG_W'($urandom_range(0, 31));
                floors = FLOOR_W'($urandom_range(0, 40));
            end else begin
                eggs = EGG_W'($urandom_range(0, 3));
                floors = FLOOR_W'($urandom_range(0, 2047));
            end
            send_query(eggs, floors);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        query_idle_pct = 37;
        answer_stall_pct = 85;
        test_base_cases();
        test_field_extremes();
        wait_for_answers();
        test_random_queries(26);
        wait_for_answers();
        query_idle_pct = 85;
        answer_stall_pct = 37;
        test_random_queries(26);
        query_idle_pct = 0;
        answer_stall_pct = 0;
        test_random_queries(25);
        wait_for_answers();
        repeat (20) @(posedge i_clk);
        $display("%0d queries sent and %0d answers checked", queries_sent, answers_checked);
        $display("egg counts 0..31 and floor counts 0..2047 with saturation, under idling");
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d answers outstanding", expected_drops.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
